// ===== sv/slice_median_nan_mode_macros.svh =====
// assertion macros for the slice median block
`ifndef SLICE_MEDIAN_NAN_MODE_MACROS_SVH
`define SLICE_MEDIAN_NAN_MODE_MACROS_SVH

// same-cycle implication
`define SMN_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SMN_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/smn_pkg.sv =====
// shared types and constants for the slice median block
package smn_pkg;

   localparam int MAX_SLICE_LEN = 64;
   localparam int ADDR_W        = (MAX_SLICE_LEN > 1) ? $clog2(MAX_SLICE_LEN) : 1;
   localparam int CNT_W         = $clog2(MAX_SLICE_LEN + 1);
   localparam int DATA_W        = 32;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SLICE_LEN);

   typedef struct packed {
      logic signed [DATA_W-1:0] sample_value;
      logic                     sample_is_nan;
      logic                     last_in_slice;
   } smn_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] median_value;
      logic                     median_is_nan;
   } smn_rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] kept_count;
      logic             nan_seen;
   } smn_status_type;

endpackage

// ===== sv/smn_ram.sv =====
// generic single-write, single-read ram with registered read data
module smn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/smn_core.sv =====
// sorted-insert sequencer around the sample ram, plus median readout
module smn_core
   import smn_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  smn_req_type    req_data,
   input  logic           nan_mode,
   output logic           res_valid,
   input  logic           res_ready,
   output smn_rsp_type    res_data,
   output smn_status_type status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SHIFT = 3'd1;
   localparam logic [2:0] ST_PLACE = 3'd2;
   localparam logic [2:0] ST_FINAL = 3'd3;
   localparam logic [2:0] ST_MID0  = 3'd4;
   localparam logic [2:0] ST_MID1  = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [2:0]               state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic signed [DATA_W-1:0] samp_ff, samp_in;
   logic                     last_ff, last_in;
   logic                     nan_seen_ff, nan_seen_in;
   logic [DATA_W-1:0]        lo_ff, lo_in;
   smn_rsp_type              res_ff, res_in;

   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic [ADDR_W-1:0]        rd_addr;
   logic [DATA_W-1:0]        rd_data;

   logic [CNT_W-1:0]         half_cnt;
   logic [CNT_W-1:0]         cnt_m1;
   logic [DATA_W:0]          mid_sum;
   logic [2:0]               after_ins;

   smn_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_SLICE_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign half_cnt = count_ff >> 1;
   assign cnt_m1   = count_ff - CNT_W'(1);
   // 33-bit sum, dropping bit 0 floors toward minus infinity
   assign mid_sum  = {lo_ff[DATA_W-1], lo_ff} + {rd_data[DATA_W-1], rd_data};
   assign after_ins = last_ff ? ST_FINAL : ST_IDLE;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      samp_in     = samp_ff;
      last_in     = last_ff;
      nan_seen_in = nan_seen_ff;
      lo_in       = lo_ff;
      res_in      = res_ff;
      wr_en       = 1'b0;
      wr_addr     = pos_ff;
      wr_data     = samp_ff;
      rd_addr     = '0;
      req_ready   = 1'b0;
      res_valid   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               samp_in = req_data.sample_value;
               last_in = req_data.last_in_slice;
               if (req_data.sample_is_nan || count_ff == MAX_COUNT) begin
                  // nan sample, or store full: nothing goes to the ram
                  if (req_data.sample_is_nan) begin
                     nan_seen_in = 1'b1;
                  end
                  state_in = req_data.last_in_slice ? ST_FINAL : ST_IDLE;
               end else if (count_ff == '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = req_data.sample_value;
                  count_in = count_ff + CNT_W'(1);
                  state_in = req_data.last_in_slice ? ST_FINAL : ST_IDLE;
               end else begin
                  rd_addr  = cnt_m1[ADDR_W-1:0];
                  pos_in   = count_ff[ADDR_W-1:0];
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            wr_en = 1'b1;
            if (samp_ff < $signed(rd_data)) begin
               // move the larger entry up one slot
               wr_data = rd_data;
               pos_in  = pos_ff - ADDR_W'(1);
               if (pos_ff == ADDR_W'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_addr = pos_ff - ADDR_W'(2);
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = after_ins;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
            state_in = after_ins;
         end
         ST_FINAL: begin
            if (count_ff == '0 || (nan_mode && nan_seen_ff)) begin
               res_in.median_value  = '0;
               res_in.median_is_nan = 1'b1;
               state_in             = ST_EMIT;
            end else if (count_ff[0]) begin
               rd_addr  = half_cnt[ADDR_W-1:0];
               state_in = ST_MID1;
            end else begin
               rd_addr  = ADDR_W'(half_cnt - CNT_W'(1));
               state_in = ST_MID0;
            end
         end
         ST_MID0: begin
            lo_in    = rd_data;
            rd_addr  = half_cnt[ADDR_W-1:0];
            state_in = ST_MID1;
         end
         ST_MID1: begin
            res_in.median_value  = count_ff[0] ? $signed(rd_data)
                                               : $signed(mid_sum[DATA_W:1]);
            res_in.median_is_nan = 1'b0;
            state_in             = ST_EMIT;
         end
         ST_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               count_in    = '0;
               nan_seen_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         nan_seen_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         nan_seen_ff <= nan_seen_in;
      end
      pos_ff  <= pos_in;
      samp_ff <= samp_in;
      last_ff <= last_in;
      lo_ff   <= lo_in;
      res_ff  <= res_in;
   end

   assign res_data          = res_ff;
   assign status.kept_count = count_ff;
   assign status.nan_seen   = nan_seen_ff;

endmodule

// ===== sv/slice_median_nan_mode.sv =====
// top level of the streaming slice median with nan policy
// usage:
//   req_* carries one sample per beat (value, nan flag, last-of-slice flag)
//   with valid/ready. each non-nan sample is insertion-sorted into a 64-entry
//   ram unless it is full; nan samples only set a flag. rsp_* carries one beat
//   per slice, the median (zero with median_is_nan set when the result is nan).
//   csr_wr_en/csr_wr_data write nan_mode (0 omit nan, 1 any nan gives nan).
// sample intake and median readout:
//   a sample is taken in one beat; a non-nan sample then keeps req_ready low
//   while each larger stored entry moves up one slot (one read and one write
//   per cycle of the sample ram) and while it is placed. nan samples and
//   samples that land on top move no entries.
//   once the last sample of a slice is inserted, the core reads the middle
//   entry (both, added and halved, for an even count) and registers the median
//   for the response register; a nan result skips the reads.
// reset: synchronous, active high; empties the slice, sets nan_mode to 1.
//   ram contents are not cleared, entries are only read after being written.
// stall: the response register holds one finished median; the core waits
//   with its result while that register is full and not drained.
module slice_median_nan_mode
   import smn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  smn_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output smn_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

`include "slice_median_nan_mode_macros.svh"

   logic           nan_mode_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   smn_rsp_type    rsp_data_ff, rsp_data_in;

   logic           core_res_valid;
   logic           core_res_ready;
   smn_rsp_type    core_res_data;
   smn_status_type core_status;
   logic           handoff;

   // sorting sequencer and sample store
   smn_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .nan_mode  (nan_mode_ff),
      .res_valid (core_res_valid),
      .res_ready (core_res_ready),
      .res_data  (core_res_data),
      .status    (core_status)
   );

   // response slot is free when empty or being drained this cycle
   assign core_res_ready = !rsp_valid_ff || rsp_ready;
   assign handoff        = core_res_valid && core_res_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (handoff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nan_mode_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            nan_mode_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks on the core and the response slot
   `SMN_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
                   core_status.kept_count <= MAX_COUNT, "kept count beyond store depth")
   `SMN_ASSERT_NOW(a_nan_zero, clock, reset, rsp_valid && rsp_data.median_is_nan,
                   rsp_data.median_value == '0, "nan median with nonzero value")
   `SMN_ASSERT_NOW(a_busy_no_take, clock, reset, core_res_valid,
                   !req_ready, "sample taken while a median is pending")
   `SMN_ASSERT_NEXT(a_slice_cleared, clock, reset, handoff,
                    core_status.kept_count == '0 && !core_status.nan_seen,
                    "slice state not cleared after median")

endmodule
